// ===== design/wvr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wvr_pkg;

   localparam int WARP_DEPTH = 64;
   localparam int INDEX_BITS = 32;

   localparam int CNT_W = $clog2(WARP_DEPTH + 1);
   localparam int IDX_W = $clog2(WARP_DEPTH);
   // wide enough for count + three appends and for count + window
   localparam int SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 2;

   localparam int GROUP_SIZE = 16;
   localparam int NUM_GROUPS = (WARP_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_DEPTH  = NUM_GROUPS * GROUP_SIZE;

   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_WARP_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REUSE_WINDOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRIANGLE_CAP  = 2'd2;

   localparam logic [6:0] RESET_WARP_CAPACITY = 7'd32;
   localparam logic [6:0] RESET_REUSE_WINDOW  = 7'd32;
   localparam logic [7:0] RESET_TRIANGLE_CAP  = 8'd32;

   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [WARP_DEPTH-1:0][INDEX_BITS-1:0] entries_type;
   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic [6:0] warp_capacity;
      logic [6:0] reuse_window;
      logic [7:0] triangle_cap;
   } cfg_type;

   typedef struct packed {
      logic             commit;
      logic             restart;
      logic [2:0]       we;
      logic [IDX_W-1:0] pos_a;
      logic [IDX_W-1:0] pos_b;
      logic [IDX_W-1:0] pos_c;
   } write_type;

   typedef struct packed {
      logic        warp_closed;
      logic [6:0]  closed_size;
      logic        new_a;
      logic        new_b;
      logic        new_c;
      logic [6:0]  warp_fill;
      logic [31:0] invocation_total;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_REDUCE,
      ST_DECIDE
   } state_type;

endpackage

`default_nettype wire

// ===== design/wvr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wvr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] index_a;
   logic [31:0] index_b;
   logic [31:0] index_c;
   logic        end_of_mesh;

   modport source (output valid, output index_a, output index_b, output index_c,
                   output end_of_mesh, input ready);
   modport sink (input valid, input index_a, input index_b, input index_c,
                 input end_of_mesh, output ready);
endinterface

interface wvr_rsp_if;
   logic        valid;
   logic        ready;
   logic        warp_closed;
   logic [6:0]  closed_size;
   logic        new_a;
   logic        new_b;
   logic        new_c;
   logic [6:0]  warp_fill;
   logic [31:0] invocation_total;

   modport source (output valid, output warp_closed, output closed_size, output new_a,
                   output new_b, output new_c, output warp_fill,
                   output invocation_total, input ready);
   modport sink (input valid, input warp_closed, input closed_size, input new_a,
                 input new_b, input new_c, input warp_fill, input invocation_total,
                 output ready);
endinterface

`default_nettype wire

// ===== design/wvr_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wvr_store (
   input  wire                   clock,
   input  wvr_pkg::write_type    wr,
   input  wvr_pkg::index_type    idx_a,
   input  wvr_pkg::index_type    idx_b,
   input  wvr_pkg::index_type    idx_c,
   input  wvr_pkg::count_type    warp_count,
   input  wire [6:0]             reuse_window,
   output wvr_pkg::entries_type  entries,
   output logic [wvr_pkg::WARP_DEPTH-1:0] win_mask
);

   wvr_pkg::entries_type entries_ff;

   always_ff @(posedge clock) begin
      for (int j = 0; j < wvr_pkg::WARP_DEPTH; j++) begin
         if (wr.commit) begin
            if (wr.restart) begin
               if (j == 0) entries_ff[j] <= idx_a;
               else if (j == 1) entries_ff[j] <= idx_b;
               else if (j == 2) entries_ff[j] <= idx_c;
            end else if (wr.we[0] && wr.pos_a == wvr_pkg::IDX_W'(j)) begin
               entries_ff[j] <= idx_a;
            end else if (wr.we[1] && wr.pos_b == wvr_pkg::IDX_W'(j)) begin
               entries_ff[j] <= idx_b;
            end else if (wr.we[2] && wr.pos_c == wvr_pkg::IDX_W'(j)) begin
               entries_ff[j] <= idx_c;
            end
         end
      end
   end

   // an entry is searched when it is filled and among the newest reuse_window
   always_comb begin
      for (int j = 0; j < wvr_pkg::WARP_DEPTH; j++) begin
         win_mask[j] = (wvr_pkg::SUM_W'(j) < wvr_pkg::SUM_W'(warp_count)) &&
                       (wvr_pkg::SUM_W'(j) + wvr_pkg::SUM_W'(reuse_window) >=
                        wvr_pkg::SUM_W'(warp_count));
      end
   end

   assign entries = entries_ff;

endmodule

`default_nettype wire

// ===== design/wvr_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wvr_lane (
   input  wire                   clock,
   input  wvr_pkg::index_type    idx,
   input  wvr_pkg::entries_type  entries,
   input  wire [wvr_pkg::WARP_DEPTH-1:0] win_mask,
   output logic                  hit
);

   logic [wvr_pkg::PAD_DEPTH-1:0]  match_in;
   logic [wvr_pkg::PAD_DEPTH-1:0]  match_ff;
   logic [wvr_pkg::NUM_GROUPS-1:0] group_in;
   logic [wvr_pkg::NUM_GROUPS-1:0] group_ff;

   always_comb begin
      match_in = '0;
      for (int j = 0; j < wvr_pkg::WARP_DEPTH; j++) begin
         match_in[j] = win_mask[j] && (entries[j] == idx);
      end
   end

   always_comb begin
      for (int g = 0; g < wvr_pkg::NUM_GROUPS; g++) begin
         group_in[g] = |match_ff[g*wvr_pkg::GROUP_SIZE +: wvr_pkg::GROUP_SIZE];
      end
   end

   // two registered levels of the or tree, stable while the item is held
   always_ff @(posedge clock) begin
      match_ff <= match_in;
      group_ff <= group_in;
   end

   assign hit = |group_ff;

endmodule

`default_nettype wire

// ===== design/wvr_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wvr_merge (
   input  wire [2:0]            hit,
   input  wire                  commit,
   input  wire                  end_of_mesh,
   input  wvr_pkg::cfg_type     cfg,
   input  wvr_pkg::count_type   warp_count,
   input  wire [7:0]            tri_count,
   input  wire [31:0]           total_count,
   output wvr_pkg::write_type   wr,
   output wvr_pkg::count_type   warp_count_in,
   output logic [7:0]           tri_count_in,
   output logic [31:0]          total_count_in,
   output wvr_pkg::result_type  result
);

   localparam logic [wvr_pkg::SUM_W-1:0] DEPTH_EXT = wvr_pkg::SUM_W'(wvr_pkg::WARP_DEPTH);

   logic [1:0]                missing;
   logic [wvr_pkg::SUM_W-1:0] count_ext;
   logic [wvr_pkg::SUM_W-1:0] cap_ext;
   logic                      close;
   logic [wvr_pkg::SUM_W-1:0] pos_a;
   logic [wvr_pkg::SUM_W-1:0] pos_b;
   logic [wvr_pkg::SUM_W-1:0] pos_c;
   logic                      we_a;
   logic                      we_b;
   logic                      we_c;
   logic [wvr_pkg::SUM_W-1:0] append_fill;
   logic [wvr_pkg::SUM_W-1:0] fill;
   logic [31:0]               total_pre;

   always_comb begin
      missing   = 2'(!hit[0]) + 2'(!hit[1]) + 2'(!hit[2]);
      count_ext = wvr_pkg::SUM_W'(warp_count);
      cap_ext   = (wvr_pkg::SUM_W'(cfg.warp_capacity) > DEPTH_EXT) ? DEPTH_EXT
                                                                  : wvr_pkg::SUM_W'(cfg.warp_capacity);
      close     = (count_ext + wvr_pkg::SUM_W'(missing) > cap_ext) ||
                  (tri_count >= cfg.triangle_cap);

      // missing indices go in order a, b, c at the tail of the warp
      pos_a       = count_ext;
      we_a        = !hit[0] && (pos_a < DEPTH_EXT);
      pos_b       = pos_a + wvr_pkg::SUM_W'(we_a);
      we_b        = !hit[1] && (pos_b < DEPTH_EXT);
      pos_c       = pos_b + wvr_pkg::SUM_W'(we_b);
      we_c        = !hit[2] && (pos_c < DEPTH_EXT);
      append_fill = pos_c + wvr_pkg::SUM_W'(we_c);

      fill      = close ? wvr_pkg::SUM_W'(3) : append_fill;
      total_pre = close ? total_count + 32'(warp_count) : total_count;

      wr.commit  = commit;
      wr.restart = close;
      wr.we      = close ? 3'b000 : {we_c, we_b, we_a};
      wr.pos_a   = pos_a[wvr_pkg::IDX_W-1:0];
      wr.pos_b   = pos_b[wvr_pkg::IDX_W-1:0];
      wr.pos_c   = pos_c[wvr_pkg::IDX_W-1:0];

      result.warp_closed      = close;
      result.closed_size      = close ? 7'(warp_count) : 7'd0;
      result.new_a            = close || !hit[0];
      result.new_b            = close || !hit[1];
      result.new_c            = close || !hit[2];
      result.warp_fill        = 7'(fill);
      result.invocation_total = end_of_mesh ? total_pre + 32'(fill) : total_pre;

      if (end_of_mesh) begin
         warp_count_in  = '0;
         tri_count_in   = 8'd0;
         total_count_in = 32'd0;
      end else begin
         warp_count_in  = fill[wvr_pkg::CNT_W-1:0];
         total_count_in = total_pre;
         priority if (close) tri_count_in = 8'd1;
         else if (tri_count == 8'd255) tri_count_in = tri_count;
         else tri_count_in = tri_count + 8'd1;
      end
   end

endmodule

`default_nettype wire

// ===== design/warp_vertex_reuse_model.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Warp vertex reuse counter for indexed triangle lists.
// req_bus carries one triangle per transfer: three vertex indices and an
// end_of_mesh flag. rsp_bus returns exactly one result per triangle: whether
// the open warp was closed and its size, which indices were appended, the
// warp fill and the running invocation total (32-bit, wrapping).
// After the request transfer a triangle passes the match, reduce and decide
// steps. Each lane (one per vertex index) compares its index against every
// warp entry and reduces the matches through a two-level registered or tree,
// then the merge step updates the warp. A new triangle is taken in the cycle
// its predecessor commits, and not before.
// The result sits in an output register; while the receiver stalls the next
// triangle still runs through the lanes and waits in its final step until
// the output register is free.
// csr_we writes warp_capacity, reuse_window or triangle_cap; write only while
// no triangle is in flight. Reset (synchronous) restores the default
// registers and empties the warp and the total; warp entries are not cleared
// since only filled entries are ever searched, so no clearing pass is needed.
module warp_vertex_reuse_model (
   input  wire                           clock,
   input  wire                           reset,
   wvr_req_if.sink                       req_bus,
   wvr_rsp_if.source                     rsp_bus,
   input  wire                           csr_we,
   input  wire [wvr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [wvr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   wvr_pkg::state_type   state_ff;
   wvr_pkg::state_type   state_in;
   wvr_pkg::cfg_type     cfg_ff;
   wvr_pkg::index_type   idx_a_ff;
   wvr_pkg::index_type   idx_b_ff;
   wvr_pkg::index_type   idx_c_ff;
   logic                 eom_ff;
   wvr_pkg::count_type   warp_count_ff;
   wvr_pkg::count_type   warp_count_in;
   logic [7:0]           tri_count_ff;
   logic [7:0]           tri_count_in;
   logic [31:0]          total_count_ff;
   logic [31:0]          total_count_in;
   logic                 rsp_valid_ff;
   wvr_pkg::result_type  result_ff;
   wvr_pkg::result_type  result_in;
   wvr_pkg::write_type   wr;
   wvr_pkg::entries_type entries;
   logic [wvr_pkg::WARP_DEPTH-1:0] win_mask;
   logic [2:0]           hit;
   logic                 commit;
   logic                 req_take;

   always_comb begin
      unique case (state_ff)
         wvr_pkg::ST_IDLE:   state_in = req_take ? wvr_pkg::ST_MATCH : wvr_pkg::ST_IDLE;
         wvr_pkg::ST_MATCH:  state_in = wvr_pkg::ST_REDUCE;
         wvr_pkg::ST_REDUCE: state_in = wvr_pkg::ST_DECIDE;
         wvr_pkg::ST_DECIDE: begin
            priority if (!commit) state_in = wvr_pkg::ST_DECIDE;
            else if (req_take) state_in = wvr_pkg::ST_MATCH;
            else state_in = wvr_pkg::ST_IDLE;
         end
         default:            state_in = wvr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      commit        = (state_ff == wvr_pkg::ST_DECIDE) && (!rsp_valid_ff || rsp_bus.ready);
      req_bus.ready = (state_ff == wvr_pkg::ST_IDLE) || commit;
   end

   assign req_take = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= wvr_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         warp_count_ff  <= '0;
         tri_count_ff   <= 8'd0;
         total_count_ff <= 32'd0;
         cfg_ff.warp_capacity <= wvr_pkg::RESET_WARP_CAPACITY;
         cfg_ff.reuse_window  <= wvr_pkg::RESET_REUSE_WINDOW;
         cfg_ff.triangle_cap  <= wvr_pkg::RESET_TRIANGLE_CAP;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff   <= 1'b1;
            warp_count_ff  <= warp_count_in;
            tri_count_ff   <= tri_count_in;
            total_count_ff <= total_count_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               wvr_pkg::REG_WARP_CAPACITY: cfg_ff.warp_capacity <= csr_wdata[6:0];
               wvr_pkg::REG_REUSE_WINDOW:  cfg_ff.reuse_window  <= csr_wdata[6:0];
               wvr_pkg::REG_TRIANGLE_CAP:  cfg_ff.triangle_cap  <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         idx_a_ff <= req_bus.index_a[wvr_pkg::INDEX_BITS-1:0];
         idx_b_ff <= req_bus.index_b[wvr_pkg::INDEX_BITS-1:0];
         idx_c_ff <= req_bus.index_c[wvr_pkg::INDEX_BITS-1:0];
         eom_ff   <= req_bus.end_of_mesh;
      end
      if (commit) begin
         result_ff <= result_in;
      end
   end

   wvr_store u_store (
      .clock        (clock),
      .wr           (wr),
      .idx_a        (idx_a_ff),
      .idx_b        (idx_b_ff),
      .idx_c        (idx_c_ff),
      .warp_count   (warp_count_ff),
      .reuse_window (cfg_ff.reuse_window),
      .entries      (entries),
      .win_mask     (win_mask)
   );

   wvr_lane u_lane_a (
      .clock    (clock),
      .idx      (idx_a_ff),
      .entries  (entries),
      .win_mask (win_mask),
      .hit      (hit[0])
   );

   wvr_lane u_lane_b (
      .clock    (clock),
      .idx      (idx_b_ff),
      .entries  (entries),
      .win_mask (win_mask),
      .hit      (hit[1])
   );

   wvr_lane u_lane_c (
      .clock    (clock),
      .idx      (idx_c_ff),
      .entries  (entries),
      .win_mask (win_mask),
      .hit      (hit[2])
   );

   wvr_merge u_merge (
      .hit            (hit),
      .commit         (commit),
      .end_of_mesh    (eom_ff),
      .cfg            (cfg_ff),
      .warp_count     (warp_count_ff),
      .tri_count      (tri_count_ff),
      .total_count    (total_count_ff),
      .wr             (wr),
      .warp_count_in  (warp_count_in),
      .tri_count_in   (tri_count_in),
      .total_count_in (total_count_in),
      .result         (result_in)
   );

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.warp_closed      = result_ff.warp_closed;
   assign rsp_bus.closed_size      = result_ff.closed_size;
   assign rsp_bus.new_a            = result_ff.new_a;
   assign rsp_bus.new_b            = result_ff.new_b;
   assign rsp_bus.new_c            = result_ff.new_c;
   assign rsp_bus.warp_fill        = result_ff.warp_fill;
   assign rsp_bus.invocation_total = result_ff.invocation_total;

   a_take_starts_match: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == wvr_pkg::ST_MATCH)
      else $error("accepted triangle did not start the match step");

   a_commit_gives_result: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed triangle produced no result");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      wvr_pkg::SUM_W'(warp_count_ff) <= wvr_pkg::SUM_W'(wvr_pkg::WARP_DEPTH))
      else $error("warp fill beyond depth");

   a_mesh_end_clears: assert property (@(posedge clock) disable iff (reset)
      commit && eom_ff |=> warp_count_ff == '0 && total_count_ff == 32'd0)
      else $error("end of mesh did not clear the warp");

endmodule

`default_nettype wire

// ===== tb/wvr_reuse_checker.sv =====
`timescale 1ns / 1ps

module wvr_reuse_checker (
   input  wire                           clock,
   input  wire                           reset,
   wvr_req_if                            req_bus,
   wvr_rsp_if                            rsp_bus,
   input  wire                           csr_we,
   input  wire [wvr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [wvr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                            fail_count,
   output int                            pending
);

   // shadow of the open warp and the running count
   wvr_pkg::index_type warp_slot [wvr_pkg::WARP_DEPTH];
   int                 warp_used;
   int                 tris_in_warp;
   logic [31:0]        invocations;

   logic [6:0]  capacity_reg;
   logic [6:0]  window_reg;
   logic [7:0]  tri_cap_reg;

   wvr_pkg::result_type warp_results_due [$];

   function automatic logic seen_recently(wvr_pkg::index_type v);
      for (int j = 0; j < warp_used; j++) begin
         if (warp_used - j <= window_reg && warp_slot[j] == v) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic wvr_pkg::result_type account_triangle(wvr_pkg::index_type a,
                                                            wvr_pkg::index_type b,
                                                            wvr_pkg::index_type c,
                                                            logic eom);
      wvr_pkg::index_type  idx [3];
      logic                hit [3];
      int                  missing;
      int                  cap;
      wvr_pkg::result_type r;
      idx[0] = a;
      idx[1] = b;
      idx[2] = c;
      missing = 0;
      r = '0;
      // every lookup sees the warp as it stood before this triangle
      for (int k = 0; k < 3; k++) begin
         hit[k] = seen_recently(idx[k]);
         if (!hit[k]) missing++;
      end
      cap = (capacity_reg > wvr_pkg::WARP_DEPTH) ? wvr_pkg::WARP_DEPTH : int'(capacity_reg);
      if (warp_used + missing > cap || tris_in_warp >= tri_cap_reg) begin
         r.warp_closed = 1'b1;
         r.closed_size = 7'(warp_used);
         invocations += 32'(warp_used);
         for (int k = 0; k < 3; k++) warp_slot[k] = idx[k];
         r.new_a = 1'b1;
         r.new_b = 1'b1;
         r.new_c = 1'b1;
         warp_used = 3;
         tris_in_warp = 1;
      end else begin
         for (int k = 0; k < 3; k++) begin
            if (!hit[k] && warp_used < wvr_pkg::WARP_DEPTH) begin
               warp_slot[warp_used] = idx[k];
               warp_used++;
            end
         end
         r.new_a = !hit[0];
         r.new_b = !hit[1];
         r.new_c = !hit[2];
         if (tris_in_warp < 255) tris_in_warp++;
      end
      r.warp_fill = 7'(warp_used);
      if (eom) begin
         invocations += 32'(warp_used);
         r.invocation_total = invocations;
         warp_used = 0;
         tris_in_warp = 0;
         invocations = '0;
      end else begin
         r.invocation_total = invocations;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      wvr_pkg::result_type want;
      wvr_pkg::result_type got;
      if (reset) begin
         warp_used = 0;
         tris_in_warp = 0;
         invocations = '0;
         capacity_reg = wvr_pkg::RESET_WARP_CAPACITY;
         window_reg = wvr_pkg::RESET_REUSE_WINDOW;
         tri_cap_reg = wvr_pkg::RESET_TRIANGLE_CAP;
         warp_results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               wvr_pkg::REG_WARP_CAPACITY: capacity_reg = csr_wdata[6:0];
               wvr_pkg::REG_REUSE_WINDOW:  window_reg = csr_wdata[6:0];
               wvr_pkg::REG_TRIANGLE_CAP:  tri_cap_reg = csr_wdata[7:0];
               default: ;
            endcase
         end
         // result side first: a result never belongs to the triangle taken this edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.warp_closed = rsp_bus.warp_closed;
            got.closed_size = rsp_bus.closed_size;
            got.new_a = rsp_bus.new_a;
            got.new_b = rsp_bus.new_b;
            got.new_c = rsp_bus.new_c;
            got.warp_fill = rsp_bus.warp_fill;
            got.invocation_total = rsp_bus.invocation_total;
            if (warp_results_due.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result transfer with no triangle outstanding", $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = warp_results_due.pop_front();
               if (got.warp_closed !== want.warp_closed || got.closed_size !== want.closed_size ||
                   got.new_a !== want.new_a || got.new_b !== want.new_b ||
                   got.new_c !== want.new_c || got.warp_fill !== want.warp_fill ||
                   got.invocation_total !== want.invocation_total) begin
                  if (fail_count < 10) begin
                     $display("%0t: expected closed=%0d size=%0d new=%b%b%b fill=%0d total=%0d",
                              $realtime, want.warp_closed, want.closed_size, want.new_a,
                              want.new_b, want.new_c, want.warp_fill, want.invocation_total);
                     $display("%0t:   actual closed=%0d size=%0d new=%b%b%b fill=%0d total=%0d",
                              $realtime, got.warp_closed, got.closed_size, got.new_a,
                              got.new_b, got.new_c, got.warp_fill, got.invocation_total);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            warp_results_due = {warp_results_due,
                                account_triangle(req_bus.index_a, req_bus.index_b,
                                                 req_bus.index_c, req_bus.end_of_mesh)};
      end
      pending <= warp_results_due.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD = 150;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 130;
   localparam int RANDOM_PHASE = 10;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_we;
   logic [wvr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [wvr_pkg::CSR_DATA_W-1:0] csr_wdata;
   int                             fail_count;
   int                             pending;
   int                             idle_cycles = 0;
   int                             hold_requests = 0;
   logic                           idle_on = 1'b1;

   // settings per random phase; the last one runs without idling
   logic [wvr_pkg::CSR_DATA_W-1:0] phase_cap [PHASES] = '{8'd32, 8'd64, 8'd127, 8'd3, 8'd0,
                                                          8'd2, 8'd32, 8'd32, 8'hC8, 8'd16,
                                                          8'd0, 8'd48};
   logic [wvr_pkg::CSR_DATA_W-1:0] phase_win [PHASES] = '{8'd32, 8'd64, 8'd127, 8'd1, 8'd0,
                                                          8'd32, 8'd0, 8'd32, 8'h9F, 8'd8,
                                                          8'd0, 8'd24};
   logic [wvr_pkg::CSR_DATA_W-1:0] phase_tri [PHASES] = '{8'd32, 8'd255, 8'd255, 8'd1, 8'd0,
                                                          8'd32, 8'd32, 8'd0, 8'hFF, 8'd10,
                                                          8'd0, 8'd40};

   wvr_req_if req_bus();
   wvr_rsp_if rsp_bus();

   warp_vertex_reuse_model dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wvr_reuse_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side pacing: random stalls, plus a long hold on request
   initial begin : rsp_pacing
      int held;
      int holds_done;
      holds_done = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_bus.ready <= 1'b0;
            held = 0;
            while (held < LONG_HOLD) begin
               @(posedge clock);
               held++;
            end
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            // the loop edge also keeps ready low
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // offer one triangle and hold it until its transfer
   task automatic send_triangle(input wvr_pkg::index_type a, input wvr_pkg::index_type b,
                                input wvr_pkg::index_type c, input logic eom);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.index_a <= a;
      req_bus.index_b <= b;
      req_bus.index_c <= c;
      req_bus.end_of_mesh <= eom;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_settings(input logic [wvr_pkg::CSR_DATA_W-1:0] cap,
                                input logic [wvr_pkg::CSR_DATA_W-1:0] win,
                                input logic [wvr_pkg::CSR_DATA_W-1:0] tcap);
      csr_we <= 1'b1;
      csr_index <= wvr_pkg::REG_WARP_CAPACITY;
      csr_wdata <= cap;
      @(posedge clock);
      csr_index <= wvr_pkg::REG_REUSE_WINDOW;
      csr_wdata <= win;
      @(posedge clock);
      csr_index <= wvr_pkg::REG_TRIANGLE_CAP;
      csr_wdata <= tcap;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int                             pick;
      wvr_pkg::index_type             a;
      wvr_pkg::index_type             b;
      wvr_pkg::index_type             c;
      logic                           eom;
      wvr_pkg::index_type             mesh_next;
      logic [wvr_pkg::CSR_DATA_W-1:0] cap;
      logic [wvr_pkg::CSR_DATA_W-1:0] win;
      logic [wvr_pkg::CSR_DATA_W-1:0] tcap;

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= wvr_pkg::REG_WARP_CAPACITY;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.index_a <= '0;
      req_bus.index_b <= '0;
      req_bus.index_c <= '0;
      req_bus.end_of_mesh <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default settings: repeats inside a triangle, extreme indices, full warp
      send_triangle(32'd0, 32'd0, 32'd0, 1'b0);
      send_triangle(32'd0, 32'd1, 32'd2, 1'b0);
      send_triangle(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_triangle(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_triangle(32'hAAAA_AAAA, 32'h5555_5555, 32'd1, 1'b1);
      for (int i = 0; i < 11; i++)
         send_triangle(32'(100 + 3 * i), 32'(101 + 3 * i), 32'(102 + 3 * i), 1'b0);
      send_triangle(32'd100, 32'd150, 32'd200, 1'b1);

      // tiny capacity, no window, no triangle budget
      drain();
      load_settings(8'd2, 8'd0, 8'd0);
      send_triangle(32'd5, 32'd5, 32'd5, 1'b0);
      send_triangle(32'd5, 32'd6, 32'd7, 1'b0);
      send_triangle(32'd5, 32'd6, 32'd7, 1'b1);

      mesh_next = $urandom;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         cap = phase_cap[p];
         win = phase_win[p];
         tcap = phase_tri[p];
         if (p == RANDOM_PHASE) begin
            cap = 8'($urandom_range(0, 255));
            win = 8'($urandom_range(0, 255));
            tcap = 8'($urandom_range(0, 255));
         end
         load_settings(cap, win, tcap);
         if (p == PHASES - 1) idle_on = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long result stall while triangles keep coming
            if ((p == 1 || p == 6) && n == 40) hold_requests++;
            if (n == 90) drain();
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // strip-like locality so lookups hit the window
               a = mesh_next - $urandom_range(0, 6);
               b = mesh_next - $urandom_range(0, 6);
               c = mesh_next;
               mesh_next = mesh_next + $urandom_range(0, 2);
            end else if (pick < 80) begin
               a = mesh_next - $urandom_range(0, 3);
               b = a;
               c = (pick < 75) ? a : mesh_next + 1;
            end else begin
               a = $urandom;
               b = $urandom;
               c = $urandom;
            end
            eom = ($urandom_range(0, 59) == 0);
            send_triangle(a, b, c, eom);
            if (eom) mesh_next = $urandom;
         end
      end

      drain();
      repeat (5) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
